// ===== hdl/pct_pkg.sv =====
// Shared types, constants and helpers for the pressure/temperature compensation block.
// Used by pct_div and pressure_temp_compensation_top; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pct_pkg;

   // calibration register indexes
   localparam logic [2:0] CalT1T2 = 3'd0;
   localparam logic [2:0] CalT3P1 = 3'd1;
   localparam logic [2:0] CalP2P3 = 3'd2;
   localparam logic [2:0] CalP4P5 = 3'd3;
   localparam logic [2:0] CalP6P7 = 3'd4;
   localparam logic [2:0] CalP8P9 = 3'd5;
   localparam int NumCal = 6;

   localparam logic signed [33:0] FineOffset = 34'sd128000;
   localparam logic [20:0]        PressFull  = 21'd1048576;
   localparam logic [63:0]        PressScale = 64'd3125;
   localparam logic [63:0]        PressBias  = 64'h0000_8000_0000_0000;

   // one restoring step per quotient bit
   localparam int DivSteps = 64;

   // one divider stage: shifting dividend/quotient word, partial remainder, sideband
   typedef struct packed {
      logic [63:0] work;
      logic [30:0] rem;
      logic [30:0] dvsr;
      logic        neg;
      logic        pvld;
      logic [31:0] temp;
      logic [31:0] fine;
   } div_type;

   // temperature results carried alongside the pressure arithmetic
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] fine;
   } tf_type;

   // after the divide: quotient and the results that ride with it
   typedef struct packed {
      logic [63:0] q;
      logic        pvld;
      logic [31:0] temp;
      logic [31:0] fine;
   } post_type;

   function automatic logic [63:0] sx16(input logic [15:0] h);
      sx16 = {{48{h[15]}}, h};
   endfunction

endpackage

`default_nettype wire

// ===== hdl/pct_mul64.sv =====
// Two-stage multiplier returning the low 64 bits of a 64 x 64 product.
// Built from three 32 x 32 partial products; uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module pct_mul64 (
   input  wire logic        clock,
   input  wire logic        adv,
   input  wire logic [63:0] a_in,
   input  wire logic [63:0] b_in,
   output logic [63:0]      p_out
);

   logic [63:0] ll_in, ll_ff;
   logic [31:0] hl_in, hl_ff;
   logic [31:0] lh_in, lh_ff;
   logic [63:0] p_in,  p_ff;

   // partial products; high x high never reaches the low word
   always_comb begin
      ll_in = a_in[31:0] * b_in[31:0];
      hl_in = 32'(a_in[63:32] * b_in[31:0]);
      lh_in = 32'(a_in[31:0] * b_in[63:32]);
      p_in  = ll_ff + {hl_ff + lh_ff, 32'b0};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ll_ff <= ll_in;
         hl_ff <= hl_in;
         lh_ff <= lh_in;
         p_ff  <= p_in;
      end
   end

   assign p_out = p_ff;

endmodule

`default_nettype wire

// ===== hdl/pct_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on pct_pkg for div_type and DivSteps.
`timescale 1ns / 1ps
`default_nettype none

module pct_div (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            adv,
   input  wire logic            in_vld,
   input  wire pct_pkg::div_type in_data,
   output logic                 out_vld,
   output pct_pkg::div_type     out_data
);

   pct_pkg::div_type st_in [pct_pkg::DivSteps];
   pct_pkg::div_type st_ff [pct_pkg::DivSteps];
   logic             vld_ff [pct_pkg::DivSteps];

   // each stage shifts in one dividend bit and tries the subtract
   always_comb begin
      pct_pkg::div_type cur;
      logic [31:0]      trial;
      logic             ge;
      for (int k = 0; k < pct_pkg::DivSteps; k++) begin
         cur       = (k == 0) ? in_data : st_ff[(k == 0) ? 0 : k - 1];
         trial     = {cur.rem, cur.work[63]};
         ge        = trial >= {1'b0, cur.dvsr};
         st_in[k]  = cur;
         st_in[k].rem  = ge ? 31'(trial - {1'b0, cur.dvsr}) : trial[30:0];
         st_in[k].work = {cur.work[62:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < pct_pkg::DivSteps; k++) vld_ff[k] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_vld;
         for (int k = 1; k < pct_pkg::DivSteps; k++) vld_ff[k] <= vld_ff[k - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < pct_pkg::DivSteps; k++) st_ff[k] <= st_in[k];
      end
   end

   assign out_vld  = vld_ff[pct_pkg::DivSteps - 1];
   assign out_data = st_ff[pct_pkg::DivSteps - 1];

endmodule

`default_nettype wire

// ===== hdl/pressure_temp_compensation_top.sv =====
// Pressure/temperature compensation, top level. Depends on pct_pkg, pct_mul64 and pct_div.
// Takes raw sensor readings and returns compensated temperature, fine term and pressure.
`timescale 1ns / 1ps
`default_nettype none

// A new raw reading pair may be taken every clock cycle unless the output stalls; each
// transaction comes out in order. Pipeline depth is set by the 64-stage bit-per-stage divider
// of the pressure formula plus the registered 64-bit multipliers around it. The whole pipeline
// holds while a result waits on rsp_tready. Calibration is written through the csr_ port,
// which is always ready; write it only while no transaction is in flight.
module pressure_temp_compensation_top (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [39:0]  req_tdata,   // raw_temp [19:0], raw_press [39:20]
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [95:0]       rsp_tdata,   // temp_centi [31:0], fine_temp [63:32],
                                          // press_q24_8 [95:64]
   output logic              rsp_tuser,   // press_valid [0]
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [2:0]   csr_index,
   input  wire logic [31:0]  csr_data
);

   logic adv;
   logic [31:0] cal_ff [pct_pkg::NumCal];

   // calibration fields
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [63:0]        p1, p2, p3, p4, p5, p6, p7, p8, p9;

   // temperature stages
   logic signed [17:0] a_s1;
   logic signed [16:0] d_s1;
   logic signed [33:0] pa_in, dd_in;
   logic signed [31:0] pa_ff, dd_ff;
   logic signed [19:0] ddh;
   logic signed [35:0] pt_in;
   logic signed [31:0] tv1_ff, pt_ff;
   logic signed [31:0] fine_ff;
   logic signed [31:0] f5;
   logic signed [33:0] x_in, x_ff;
   logic [19:0]        rp1_ff, rp2_ff, rp3_ff;
   logic [20:0]        pf_ff [5];
   logic [11:0]        vld_ff;
   pct_pkg::tf_type    tf_ff [9];

   // pressure stages before the divide
   logic [63:0] x64, xx, xp5, xp2, xxp6, xxp3, m3a, m3b;
   logic [63:0] xp5_ff [2];
   logic [63:0] xp2_ff [2];
   logic [63:0] v2, v1a_ff, nm_ff;
   logic [30:0] b31;
   logic [63:0] ma_ff;
   logic [30:0] mb_ff;
   logic        neg_ff, pv_ff;
   pct_pkg::div_type div_in, div_out;
   logic        div_vld;

   // after the divide
   pct_pkg::post_type post_ff [5];
   logic [4:0]  post_vld_ff;
   logic [63:0] ps77, ps79, m4a, m4b, mm;
   logic [63:0] p8q_ff [2];
   logic signed [63:0] sum, pr;

   logic        rsp_tvalid_ff;
   logic [95:0] rsp_tdata_ff;
   logic        rsp_tuser_ff;

   assign adv        = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   // calibration register write
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pct_pkg::NumCal; i++) cal_ff[i] <= 32'b0;
      end else if (csr_valid) begin
         case (csr_index)
            pct_pkg::CalT1T2: cal_ff[0] <= csr_data;
            pct_pkg::CalT3P1: cal_ff[1] <= csr_data;
            pct_pkg::CalP2P3: cal_ff[2] <= csr_data;
            pct_pkg::CalP4P5: cal_ff[3] <= csr_data;
            pct_pkg::CalP6P7: cal_ff[4] <= csr_data;
            pct_pkg::CalP8P9: cal_ff[5] <= csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      t1 = cal_ff[0][15:0];
      t2 = cal_ff[0][31:16];
      t3 = cal_ff[1][15:0];
      p1 = {48'b0, cal_ff[1][31:16]};
      p2 = pct_pkg::sx16(cal_ff[2][15:0]);
      p3 = pct_pkg::sx16(cal_ff[2][31:16]);
      p4 = pct_pkg::sx16(cal_ff[3][15:0]);
      p5 = pct_pkg::sx16(cal_ff[3][31:16]);
      p6 = pct_pkg::sx16(cal_ff[4][15:0]);
      p7 = pct_pkg::sx16(cal_ff[4][31:16]);
      p8 = pct_pkg::sx16(cal_ff[5][15:0]);
      p9 = pct_pkg::sx16(cal_ff[5][31:16]);
   end

   // temperature path, 32-bit wrap
   always_comb begin
      a_s1  = $signed({1'b0, req_tdata[19:3]}) - $signed({1'b0, t1, 1'b0});
      d_s1  = $signed({1'b0, req_tdata[19:4]}) - $signed({1'b0, t1});
      pa_in = a_s1 * t2;
      dd_in = d_s1 * d_s1;
      ddh   = dd_ff[31:12];
      pt_in = ddh * t3;
      f5    = fine_ff + (fine_ff <<< 2) + 32'sd128;
      x_in  = $signed({{2{fine_ff[31]}}, fine_ff}) - pct_pkg::FineOffset;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff   <= pa_in[31:0];
         dd_ff   <= dd_in[31:0];
         rp1_ff  <= req_tdata[39:20];
         tv1_ff  <= pa_ff >>> 11;
         pt_ff   <= pt_in[31:0];
         rp2_ff  <= rp1_ff;
         fine_ff <= tv1_ff + (pt_ff >>> 14);
         rp3_ff  <= rp2_ff;
         x_ff    <= x_in;
         pf_ff[0] <= pct_pkg::PressFull - {1'b0, rp3_ff};
         tf_ff[0] <= '{temp: 32'(f5 >>> 8), fine: fine_ff};
         for (int i = 1; i < 5; i++) pf_ff[i] <= pf_ff[i - 1];
         for (int i = 1; i < 9; i++) tf_ff[i] <= tf_ff[i - 1];
      end
   end

   // valid bits of the stages ahead of the divider
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[10:0], req_tvalid};
      end
   end

   // squares and first-order terms of the offset fine term
   assign x64 = {{30{x_ff[33]}}, x_ff};
   pct_mul64 u_m1a (.clock(clock), .adv(adv), .a_in(x64), .b_in(x64), .p_out(xx));
   pct_mul64 u_m1b (.clock(clock), .adv(adv), .a_in(x64), .b_in(p5),  .p_out(xp5));
   pct_mul64 u_m1c (.clock(clock), .adv(adv), .a_in(x64), .b_in(p2),  .p_out(xp2));
   pct_mul64 u_m2a (.clock(clock), .adv(adv), .a_in(xx),  .b_in(p6),  .p_out(xxp6));
   pct_mul64 u_m2b (.clock(clock), .adv(adv), .a_in(xx),  .b_in(p3),  .p_out(xxp3));

   assign v2 = xxp6 + {xp5_ff[1][46:0], 17'b0} + {p4[28:0], 35'b0};

   always_ff @(posedge clock) begin
      if (adv) begin
         xp5_ff[0] <= xp5;
         xp5_ff[1] <= xp5_ff[0];
         xp2_ff[0] <= xp2;
         xp2_ff[1] <= xp2_ff[0];
         v1a_ff    <= 64'($signed(xxp3) >>> 8) + {xp2_ff[1][51:0], 12'b0} + pct_pkg::PressBias;
         nm_ff     <= {12'b0, pf_ff[4], 31'b0} - v2;
      end
   end

   // divisor and scaled dividend
   pct_mul64 u_m3a (.clock(clock), .adv(adv), .a_in(v1a_ff), .b_in(p1),
                    .p_out(m3a));
   pct_mul64 u_m3b (.clock(clock), .adv(adv), .a_in(nm_ff), .b_in(pct_pkg::PressScale),
                    .p_out(m3b));

   // signs and magnitudes for the unsigned divide
   assign b31 = m3a[63:33];
   always_ff @(posedge clock) begin
      if (adv) begin
         ma_ff  <= m3b[63] ? 64'(64'd0 - m3b) : m3b;
         mb_ff  <= b31[30] ? 31'(31'd0 - b31) : b31;
         neg_ff <= m3b[63] ^ b31[30];
         pv_ff  <= b31 != 31'd0;
      end
   end

   always_comb begin
      div_in.work = ma_ff;
      div_in.rem  = '0;
      div_in.dvsr = mb_ff;
      div_in.neg  = neg_ff;
      div_in.pvld = pv_ff;
      div_in.temp = tf_ff[8].temp;
      div_in.fine = tf_ff[8].fine;
   end

   pct_div u_div (
      .clock(clock), .reset(reset), .adv(adv),
      .in_vld(vld_ff[11]), .in_data(div_in),
      .out_vld(div_vld), .out_data(div_out)
   );

   // signed quotient, then the second-order pressure correction
   assign ps77 = 64'($signed(post_ff[0].q) >>> 13);
   assign ps79 = 64'($signed(post_ff[2].q) >>> 13);
   pct_mul64 u_m4a (.clock(clock), .adv(adv), .a_in(p9), .b_in(ps77), .p_out(m4a));
   pct_mul64 u_m4b (.clock(clock), .adv(adv), .a_in(p8), .b_in(post_ff[0].q), .p_out(m4b));
   pct_mul64 u_m5  (.clock(clock), .adv(adv), .a_in(m4a), .b_in(ps79), .p_out(mm));

   always_ff @(posedge clock) begin
      if (adv) begin
         post_ff[0].q    <= div_out.neg ? 64'(64'd0 - div_out.work) : div_out.work;
         post_ff[0].pvld <= div_out.pvld;
         post_ff[0].temp <= div_out.temp;
         post_ff[0].fine <= div_out.fine;
         for (int i = 1; i < 5; i++) post_ff[i] <= post_ff[i - 1];
         p8q_ff[0] <= m4b;
         p8q_ff[1] <= p8q_ff[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         post_vld_ff <= '0;
      end else if (adv) begin
         post_vld_ff <= {post_vld_ff[3:0], div_vld};
      end
   end

   // final sum and output register
   always_comb begin
      sum = $signed(post_ff[4].q) + ($signed(mm) >>> 25) + ($signed(p8q_ff[1]) >>> 19);
      pr  = (sum >>> 8) + $signed({p7[59:0], 4'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (adv) begin
         rsp_tvalid_ff <= post_vld_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_tdata_ff <= {post_ff[4].pvld ? pr[31:0] : 32'd0,
                          post_ff[4].fine, post_ff[4].temp};
         rsp_tuser_ff <= post_ff[4].pvld;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;

endmodule

`default_nettype wire
